### rtl/core/rhss_pkg.sv
// ----------------------------------------------------------------------------
// rhss_pkg
// Shared types and constants for the rolling-hash substring search block.
// ----------------------------------------------------------------------------
package rhss_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int PIDX_W     = 6;
    localparam int HASH_W     = 64;
    localparam int HASH_SHIFT = 7;
    localparam int SHIFT_W    = 6;

    // Longest window whose oldest byte still lands inside the hash word.
    localparam int REM_LEN_MAX = (HASH_W - 1) / HASH_SHIFT + 1;

    // Request kinds carried on the input beat.
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_ROLL,
        ST_CHECK,
        ST_VREAD,
        ST_VCMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic pat_load;
        logic pat_restart;
        logic win_clear;
        logic win_remove;
        logic win_roll;
    } hash_cmd_t;

endpackage

### rtl/core/rhss_ram.sv
// ----------------------------------------------------------------------------
// rhss_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rhss_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rhss_hash.sv
// ----------------------------------------------------------------------------
// rhss_hash
// Pattern hash and rolling window hash, base 128 modulo 2^64.
// ----------------------------------------------------------------------------
module rhss_hash
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rhss_pkg::hash_cmd_t         cmd,
    input  logic [rhss_pkg::BYTE_W-1:0] byte_value,
    input  logic [rhss_pkg::BYTE_W-1:0] old_byte,
    input  logic [rhss_pkg::SHIFT_W-1:0] rem_shift,
    output logic                        hash_eq
);

    import rhss_pkg::*;

    logic [HASH_W-1:0] pat_hash_reg, pat_hash_next;
    logic [HASH_W-1:0] win_hash_reg, win_hash_next;

    always_comb
    begin
        pat_hash_next = pat_hash_reg;
        if (cmd.pat_load)
        begin
            if (cmd.pat_restart)
            begin
                pat_hash_next = HASH_W'(byte_value);
            end
            else
            begin
                pat_hash_next = (pat_hash_reg << HASH_SHIFT) + HASH_W'(byte_value);
            end
        end
    end

    // Removing the oldest byte and shifting in the new one happen on separate
    // cycles so that only one 64-bit add sits between registers.
    always_comb
    begin
        win_hash_next = win_hash_reg;
        if (cmd.win_clear)
        begin
            win_hash_next = '0;
        end
        else if (cmd.win_remove)
        begin
            win_hash_next = win_hash_reg - (HASH_W'(old_byte) << rem_shift);
        end
        else if (cmd.win_roll)
        begin
            win_hash_next = (win_hash_reg << HASH_SHIFT) + HASH_W'(byte_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_hash_reg <= '0;
            win_hash_reg <= '0;
        end
        else
        begin
            pat_hash_reg <= pat_hash_next;
            win_hash_reg <= win_hash_next;
        end
    end

    assign hash_eq = (win_hash_reg == pat_hash_reg);

endmodule

### rtl/core/rhss_ctrl.sv
// ----------------------------------------------------------------------------
// rhss_ctrl
// Sequencer: window pointer and fill, hash commands, byte verification,
// and the result register.
// ----------------------------------------------------------------------------
module rhss_ctrl
#(
    parameter int PAT_MAX = 64,
    localparam int PW     = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rhss_pkg::LEN_W-1:0]   pattern_len,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_req_type,
    input  logic [rhss_pkg::BYTE_W-1:0]  in_byte,
    input  logic [rhss_pkg::PIDX_W-1:0]  in_pattern_index,
    input  logic                         in_text_first,
    input  logic                         in_text_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_match_here,
    output logic                         out_found,
    output logic                         out_done_res,
    output rhss_pkg::hash_cmd_t          hash_cmd,
    output logic [rhss_pkg::BYTE_W-1:0]  hash_byte,
    output logic [rhss_pkg::SHIFT_W-1:0] rem_shift,
    input  logic                         hash_eq,
    output logic                         pat_wr_en,
    output logic [PW-1:0]                pat_wr_addr,
    output logic [rhss_pkg::BYTE_W-1:0]  pat_wr_data,
    output logic                         pat_rd_en,
    output logic [PW-1:0]                pat_rd_addr,
    input  logic [rhss_pkg::BYTE_W-1:0]  pat_rd_data,
    output logic                         win_wr_en,
    output logic [PW-1:0]                win_wr_addr,
    output logic [rhss_pkg::BYTE_W-1:0]  win_wr_data,
    output logic                         win_rd_en,
    output logic [PW-1:0]                win_rd_addr,
    input  logic [rhss_pkg::BYTE_W-1:0]  win_rd_data
);

    import rhss_pkg::*;

    localparam int FW = $clog2(PAT_MAX + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;
    localparam int SW = PW + 2;

    state_t              state_reg, state_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic                found_reg, found_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                last_reg, last_next;
    logic                rem_reg, rem_next;
    logic                match_reg, match_next;
    logic [PW-1:0]       vidx_reg, vidx_next;
    logic [PW-1:0]       vpos_reg, vpos_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_match_reg, out_match_next;
    logic                out_found_reg, out_found_next;
    logic                out_last_reg, out_last_next;

    logic [LEN_W-1:0]    len_eff;
    logic [PW-1:0]       ptr_eff;
    logic [FW-1:0]       fill_eff;
    logic [9:0]          shift_full;

    // Position of the byte that lies len places behind pointer p.
    function automatic logic [PW-1:0] back_pos(input logic [PW-1:0] p,
                                               input logic [LEN_W-1:0] l);
        logic [SW-1:0] sum;
        sum = SW'(p) + SW'(PAT_MAX) - SW'(l);
        if (sum >= SW'(PAT_MAX))
        begin
            sum = sum - SW'(PAT_MAX);
        end
        return PW'(sum);
    endfunction

    always_comb
    begin
        if (10'(pattern_len) > 10'(PAT_MAX))
        begin
            len_eff = LEN_W'(PAT_MAX);
        end
        else
        begin
            len_eff = pattern_len;
        end
    end

    assign ptr_eff    = in_text_first ? '0 : ptr_reg;
    assign fill_eff   = in_text_first ? '0 : fill_reg;
    assign shift_full = (10'(len_eff) - 10'd1) * 10'(HASH_SHIFT);
    assign rem_shift  = shift_full[SHIFT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        found_next     = found_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        match_next     = match_reg;
        vidx_next      = vidx_reg;
        vpos_next      = vpos_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_match_next = out_match_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        in_ready    = 1'b0;
        hash_cmd    = '0;
        hash_byte   = byte_reg;
        pat_wr_en   = 1'b0;
        pat_wr_addr = PW'(in_pattern_index);
        pat_wr_data = in_byte;
        pat_rd_en   = 1'b0;
        pat_rd_addr = vidx_reg;
        win_wr_en   = 1'b0;
        win_wr_addr = ptr_reg;
        win_wr_data = byte_reg;
        win_rd_en   = 1'b0;
        win_rd_addr = vpos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == REQ_PATTERN)
                    begin
                        if (10'(in_pattern_index) < 10'(PAT_MAX))
                        begin
                            pat_wr_en            = 1'b1;
                            hash_cmd.pat_load    = 1'b1;
                            hash_cmd.pat_restart = (in_pattern_index == '0);
                            hash_byte            = in_byte;
                        end
                    end
                    else
                    begin
                        byte_next = in_byte;
                        last_next = in_text_last;
                        if (in_text_first)
                        begin
                            ptr_next           = '0;
                            fill_next          = '0;
                            found_next         = 1'b0;
                            hash_cmd.win_clear = 1'b1;
                        end
                        rem_next = (len_eff != '0)
                                && (CW'(fill_eff) >= CW'(len_eff))
                                && (CW'(len_eff) <= CW'(REM_LEN_MAX));
                        // Fetch the byte that drops out of the window.
                        win_rd_en   = 1'b1;
                        win_rd_addr = back_pos(ptr_eff, len_eff);
                        state_next  = ST_REMOVE;
                    end
                end
            end
            ST_REMOVE:
            begin
                hash_cmd.win_remove = rem_reg;
                state_next          = ST_ROLL;
            end
            ST_ROLL:
            begin
                if (len_eff != '0)
                begin
                    hash_cmd.win_roll = 1'b1;
                end
                else
                begin
                    found_next = 1'b1;
                end
                win_wr_en = 1'b1;
                if (ptr_reg == PW'(PAT_MAX - 1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (fill_reg < FW'(PAT_MAX))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((len_eff != '0) && (CW'(fill_reg) >= CW'(len_eff)) && hash_eq)
                begin
                    vidx_next  = '0;
                    vpos_next  = back_pos(ptr_reg, len_eff);
                    state_next = ST_VREAD;
                end
                else
                begin
                    match_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_VREAD:
            begin
                pat_rd_en  = 1'b1;
                win_rd_en  = 1'b1;
                state_next = ST_VCMP;
            end
            ST_VCMP:
            begin
                if (pat_rd_data != win_rd_data)
                begin
                    match_next = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (CW'(vidx_reg) == CW'(len_eff) - CW'(1))
                begin
                    match_next = 1'b1;
                    found_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                    if (vpos_reg == PW'(PAT_MAX - 1))
                    begin
                        vpos_next = '0;
                    end
                    else
                    begin
                        vpos_next = vpos_reg + 1'b1;
                    end
                    state_next = ST_VREAD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = match_reg;
                    out_found_next = found_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        match_reg     <= match_next;
        vidx_reg      <= vidx_next;
        vpos_reg      <= vpos_next;
        out_match_reg <= out_match_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_match_here = out_match_reg;
    assign out_found      = out_found_reg;
    assign out_done_res   = out_last_reg;

    a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_match_reg || out_found_reg))
        else $error("match reported without found");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(PAT_MAX))
        else $error("window fill beyond window depth");

    a_text_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_req_type == REQ_TEXT)
        |=> (state_reg == ST_REMOVE) ##1 (state_reg == ST_ROLL))
        else $error("text beat did not pass through remove and roll");

    a_verify_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VCMP) |-> (CW'(vidx_reg) < CW'(len_eff)))
        else $error("verify index past pattern length");

    a_hash_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({hash_cmd.win_clear, hash_cmd.win_remove, hash_cmd.win_roll}))
        else $error("conflicting window hash commands");

endmodule

### rtl/core/rolling_hash_substring_search_top.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_search_top
// Rabin-Karp substring search over a byte stream with on-chip pattern store.
// ----------------------------------------------------------------------------
// Usage: set pattern_len through cfg_wr_en/cfg_wr_data while the block is idle,
// then send pattern bytes (tuser = 0) at ascending indices from zero, then text
// bytes (tuser = 1) with text_first set on the first byte of a search and tlast
// on the final one. Pattern beats give no result; each text beat gives exactly
// one result beat holding match_here, the sticky found flag and, on tlast, the
// end-of-search mark.
// Timing: a pattern beat is taken in the idle state, which it does not leave.
// A text beat goes from acceptance through the remove, roll, check and emit
// states before the next acceptance, its result entering the output register
// as emit is left; this is set by the read of the departing window byte from
// the window RAM and the split of the hash update into a subtract step and a
// shift-add step. When the window hash equals the pattern hash, verification
// adds a RAM read and a compare of both stores per pattern byte. Reset
// clears the hashes, window pointer, fill count, found flag and pattern
// length; the two byte stores are not cleared. If the receiver stalls, the
// result waits in the output register; the next input beat is still taken and
// worked on, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search_top
#(
    parameter int PAT_MAX = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: pattern_len.
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] byte_value, [13:8] pattern_index,
                                        // [14] text_first, [15] zero
    input  logic        s_axis_tuser,   // [0] req_type
    input  logic        s_axis_tlast,   // text_last
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] match_here, [1] found, [7:2] zero
    output logic        m_axis_tlast    // done_res
);

    import rhss_pkg::*;

    localparam int PW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    // The one configuration register.
    logic [LEN_W-1:0] pattern_len_reg;

    hash_cmd_t         hash_cmd;
    logic [BYTE_W-1:0] hash_byte;
    logic [SHIFT_W-1:0] rem_shift;
    logic              hash_eq;

    logic              pat_wr_en, pat_rd_en, win_wr_en, win_rd_en;
    logic [PW-1:0]     pat_wr_addr, pat_rd_addr, win_wr_addr, win_rd_addr;
    logic [BYTE_W-1:0] pat_wr_data, pat_rd_data, win_wr_data, win_rd_data;

    logic              res_match, res_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            pattern_len_reg <= cfg_wr_data;
        end
    end

    // Sequencer: owns the window pointer, fill count, verify walk and the
    // output register.
    rhss_ctrl #(
        .PAT_MAX (PAT_MAX)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .pattern_len      (pattern_len_reg),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_req_type      (s_axis_tuser),
        .in_byte          (s_axis_tdata[7:0]),
        .in_pattern_index (s_axis_tdata[13:8]),
        .in_text_first    (s_axis_tdata[14]),
        .in_text_last     (s_axis_tlast),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_match_here   (res_match),
        .out_found        (res_found),
        .out_done_res     (m_axis_tlast),
        .hash_cmd         (hash_cmd),
        .hash_byte        (hash_byte),
        .rem_shift        (rem_shift),
        .hash_eq          (hash_eq),
        .pat_wr_en        (pat_wr_en),
        .pat_wr_addr      (pat_wr_addr),
        .pat_wr_data      (pat_wr_data),
        .pat_rd_en        (pat_rd_en),
        .pat_rd_addr      (pat_rd_addr),
        .pat_rd_data      (pat_rd_data),
        .win_wr_en        (win_wr_en),
        .win_wr_addr      (win_wr_addr),
        .win_wr_data      (win_wr_data),
        .win_rd_en        (win_rd_en),
        .win_rd_addr      (win_rd_addr),
        .win_rd_data      (win_rd_data)
    );

    // Both hashes live here; the departing byte comes straight from the
    // window RAM read port.
    rhss_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (hash_cmd),
        .byte_value (hash_byte),
        .old_byte   (win_rd_data),
        .rem_shift  (rem_shift),
        .hash_eq    (hash_eq)
    );

    // Pattern bytes, indexed by pattern position.
    rhss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAT_MAX)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (pat_wr_en),
        .wr_addr (pat_wr_addr),
        .wr_data (pat_wr_data),
        .rd_en   (pat_rd_en),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    // Circular window of the most recent text bytes. Only one text beat is in
    // flight, so its write always completes before the next beat reads.
    rhss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAT_MAX)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (win_wr_data),
        .rd_en   (win_rd_en),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    assign m_axis_tdata = {6'b0, res_found, res_match};

endmodule

### test/rolling_hash_substring_search_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_substring_search_top_test
// Self-checking bench for the rolling-hash substring search block: a local
// copy of the search state predicts each result beat and compares it with
// what comes out, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search_top_test;

    import rhss_pkg::*;

    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 440;
    localparam int STORE_DEPTH   = 64;

    typedef struct packed {
        logic       req;
        logic [7:0] value;
        logic [5:0] index;
        logic       first;
        logic       last;
    } search_beat_t;

    typedef struct packed {
        logic match_here;
        logic found;
        logic done_res;
    } search_result_t;

    typedef logic [7:0] byte_queue_t[$];

    // Keeps its own copy of the pattern, the text window and both hashes, and
    // queues the result that each accepted text byte must produce.
    class match_tracker;
        logic [7:0]     pattern_bytes [STORE_DEPTH];
        logic [7:0]     window_bytes [STORE_DEPTH];
        logic [63:0]    pattern_sum;
        logic [63:0]    window_sum;
        logic [6:0]     length_reg;
        int unsigned    window_count;
        logic [5:0]     window_head;
        logic           found_seen;
        search_result_t pending_results[$];
        int unsigned    mismatches;
        int unsigned    pattern_loads;
        int unsigned    text_bytes;
        int unsigned    match_count;
        int unsigned    rejected_hits;

        function new();
            foreach (pattern_bytes[i])
            begin
                pattern_bytes[i] = '0;
                window_bytes[i]  = '0;
            end
            pattern_sum   = '0;
            window_sum    = '0;
            length_reg    = '0;
            window_count  = 0;
            window_head   = '0;
            found_seen    = 1'b0;
            mismatches    = 0;
            pattern_loads = 0;
            text_bytes    = 0;
            match_count   = 0;
            rejected_hits = 0;
        endfunction

        function void set_length(logic [6:0] len);
            length_reg = len;
        endfunction

        function void take_beat(search_beat_t beat);
            int unsigned    span;
            int unsigned    shift;
            logic [5:0]     slot;
            logic           hit;
            search_result_t res;
            if (beat.req == REQ_PATTERN)
            begin
                pattern_loads++;
                pattern_bytes[beat.index] = beat.value;
                if (beat.index == 0)
                    pattern_sum = 64'(beat.value);
                else
                    pattern_sum = (pattern_sum << HASH_SHIFT) + 64'(beat.value);
                return;
            end
            text_bytes++;
            if (beat.first)
            begin
                window_sum   = '0;
                window_count = 0;
                window_head  = '0;
                found_seen   = 1'b0;
            end
            span = (length_reg > STORE_DEPTH) ? STORE_DEPTH : length_reg;
            if (span == 0)
                found_seen = 1'b1;
            else
            begin
                // The departing byte only matters while it still lands inside
                // the 64-bit hash; for long patterns it has already shifted out.
                shift = HASH_SHIFT * (span - 1);
                if (window_count >= span && shift < 64)
                begin
                    slot = window_head - 6'(span);
                    window_sum = window_sum - (64'(window_bytes[slot]) << shift);
                end
                window_sum = (window_sum << HASH_SHIFT) + 64'(beat.value);
            end
            window_bytes[window_head] = beat.value;
            window_head = window_head + 6'd1;
            if (window_count < STORE_DEPTH)
                window_count++;
            hit = 1'b0;
            if (span != 0 && window_count >= span && window_sum == pattern_sum)
            begin
                hit = 1'b1;
                for (int j = 0; j < span; j++)
                begin
                    slot = window_head - 6'(span) + 6'(j);
                    if (window_bytes[slot] != pattern_bytes[j])
                        hit = 1'b0;
                end
                if (hit)
                    match_count++;
                else
                    rejected_hits++;
            end
            if (hit)
                found_seen = 1'b1;
            res.match_here = hit;
            res.found      = found_seen;
            res.done_res   = beat.last;
            pending_results = {pending_results, res};
        endfunction

        function void check_result(logic match_here, logic found, logic done_res);
            search_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat arrived with no text byte outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (match_here !== want.match_here)
            begin
                $error("match_here: expected %0b, got %0b", want.match_here, match_here);
                mismatches++;
            end
            if (found !== want.found)
            begin
                $error("found: expected %0b, got %0b", want.found, found);
                mismatches++;
            end
            if (done_res !== want.done_res)
            begin
                $error("done_res: expected %0b, got %0b", want.done_res, done_res);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    match_tracker board = new();

    bit           tx_quiet;
    bit           rx_quiet;
    int           rx_hold_req = 0;
    int           rx_hold_left = 0;
    int           idle_cycles = 0;
    bit [127:0]   lengths_used;
    logic [7:0]   alphabet [3];
    bit           alphabet_wide;

    rolling_hash_substring_search_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Draws from a narrow alphabet most of the time so that hash hits and
    // true matches turn up often; a wide phase uses any byte value.
    function automatic logic [7:0] pick_byte();
        if (alphabet_wide)
            return 8'($urandom_range(255));
        return alphabet[$urandom_range(2)];
    endfunction

    task automatic offer(search_beat_t beat);
        while (!tx_quiet && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, beat.first, beat.index, beat.value};
        s_axis_tuser  <= beat.req;
        s_axis_tlast  <= beat.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_beat(beat);
    endtask

    // Pattern beats ignore text_first and tlast, so those bits carry noise.
    task automatic load_pattern(byte_queue_t bytes, int start_index);
        search_beat_t beat;
        foreach (bytes[i])
        begin
            beat.req   = REQ_PATTERN;
            beat.value = bytes[i];
            beat.index = 6'(start_index + i);
            beat.first = 1'($urandom_range(1));
            beat.last  = 1'($urandom_range(1));
            offer(beat);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic scan_text(byte_queue_t bytes, bit start_new, int pause_at);
        search_beat_t beat;
        foreach (bytes[i])
        begin
            if (i == pause_at)
                drain_results();
            beat.req   = REQ_TEXT;
            beat.value = bytes[i];
            beat.index = 6'($urandom_range(63));
            beat.first = start_new && (i == 0);
            beat.last  = (i == bytes.size() - 1);
            offer(beat);
        end
    endtask

    task automatic write_length(logic [6:0] len);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_length(len);
        lengths_used[len] = 1'b1;
    endtask

    // Result side: random back-pressure, plus one long hold for each request.
    initial
    begin
        int holds_given;
        holds_given = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast);
            if (rx_hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_hold_req > holds_given)
            begin
                holds_given++;
                rx_hold_left  = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= rx_quiet || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no beat moved for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        byte_queue_t pat;
        byte_queue_t txt;
        byte_queue_t copy;
        int          phase;
        int          base;
        int          span;
        int          count;
        int          pick;
        int          pause_at;
        bit          keep;
        logic [6:0]  len;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_PATTERN;
        s_axis_tlast  <= 1'b0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        lengths_used  = '0;
        alphabet_wide = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every pattern slot once so that no length can reach a slot
        // that was never written.
        pat = {};
        for (int i = 0; i < STORE_DEPTH; i++)
            pat = {pat, 8'($urandom_range(255))};
        load_pattern(pat, 0);

        // Empty pattern: found from the first byte on, never a match.
        write_length(7'd0);
        txt = {8'h00, 8'hFF};
        scan_text(txt, 1'b1, -1);

        // Short pattern: text shorter than the pattern at first, one match,
        // a near miss, then a continued search without text_first.
        write_length(7'd3);
        pat = {8'h41, 8'hFF, 8'h00};
        load_pattern(pat, 0);
        txt = {8'h41, 8'h41, 8'hFF, 8'h00, 8'hFF, 8'h41, 8'hFE, 8'h00};
        scan_text(txt, 1'b1, -1);
        txt = {8'h41, 8'hFF, 8'h00};
        scan_text(txt, 1'b0, -1);

        // Eleven bytes: the oldest byte no longer reaches the hash, so a
        // window that differs only there is a hash hit the compare rejects.
        write_length(7'd11);
        pat = {};
        for (int i = 0; i < 11; i++)
            pat = {pat, 8'($urandom_range(255))};
        load_pattern(pat, 0);
        txt = pat;
        txt[0] = pat[0] ^ 8'hFF;
        txt = {txt, pat};
        scan_text(txt, 1'b1, -1);

        phase = 0;
        base  = board.pattern_loads + board.text_bytes;
        while (board.pattern_loads + board.text_bytes - base < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (phase == 0)
                len = 7'd64;
            else if (phase == 1)
                len = 7'($urandom_range(65, 127));
            else if (pick < 8)
                len = 7'd0;
            else if (pick < 11)
                len = 7'd64;
            else if (pick < 25)
                len = 7'($urandom_range(10, 11));
            else if (pick < 38)
                len = 7'd1;
            else
                len = 7'($urandom_range(2, 16));
            keep     = (phase > 1) && ($urandom_range(99) < 20);
            tx_quiet = (phase >= 5) && (phase < 8);
            rx_quiet = tx_quiet;
            write_length(len);
            span = (len > STORE_DEPTH) ? STORE_DEPTH : len;

            alphabet_wide = ($urandom_range(99) < 30);
            foreach (alphabet[i])
                alphabet[i] = 8'($urandom_range(255));
            pat = {};
            for (int i = 0; i < span; i++)
                pat = {pat, pick_byte()};
            load_pattern(pat, 0);
            // Now and then a stray load at any slot, which also spoils the hash.
            if ($urandom_range(99) < 10)
            begin
                copy = {8'($urandom_range(255))};
                load_pattern(copy, $urandom_range(63));
            end

            count = span + $urandom_range(1, (span >= 60) ? 8 : 24);
            txt = {};
            while (txt.size() < count)
            begin
                pick = $urandom_range(99);
                if (span != 0 && pick < 25)
                    txt = {txt, pat};
                else if (span != 0 && pick < 35)
                begin
                    copy = pat;
                    copy[$urandom_range(span - 1)] ^= 8'(1 << $urandom_range(7));
                    txt = {txt, copy};
                end
                else
                    txt = {txt, pick_byte()};
            end
            while (txt.size() > count)
                void'(txt.pop_back());

            // Long receiver hold while the sender keeps offering, and a sender
            // pause until every result has come back.
            if (phase == 3 || phase == 12)
                rx_hold_req++;
            pause_at = (phase == 4 || phase == 11) ? txt.size() / 2 : -1;
            scan_text(txt, !keep, pause_at);
            phase++;
        end
        drain_results();

        $display("Ran %0d text bytes and %0d pattern loads over %0d pattern lengths.",
                 board.text_bytes, board.pattern_loads, $countones(lengths_used));
        $display("Saw %0d verified matches and %0d hash hits rejected by the byte compare.",
                 board.match_count, board.rejected_hits);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/core/rhss_pkg.sv
rtl/core/rhss_ram.sv
rtl/core/rhss_hash.sv
rtl/core/rhss_ctrl.sv
rtl/core/rolling_hash_substring_search_top.sv
test/rolling_hash_substring_search_top_test.sv
